// ===== rtl/fli_pkg.sv =====
// Shared types and constants for the free-list slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package fli_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int IDX_W        = 10;
   localparam int LIMIT_W      = 11;
   localparam int STATUS_W     = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic             op;
      logic [IDX_W-1:0] item_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    granted_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/fli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/fli_engine.sv =====
// Allocation engine: link and in-use memories, free-list head, high-water mark.
`timescale 1ns / 1ps
`default_nettype none
module fli_engine #(
   parameter int CAPACITY = fli_pkg::CAPACITY_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [fli_pkg::LIMIT_W-1:0]    limit,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire fli_pkg::req_type               req_word,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      fli_pkg::rsp_type               rsp_word
);
   import fli_pkg::*;

   localparam int SW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int HW  = SW + 1;
   localparam int XW  = (SW > IDX_W) ? SW : IDX_W;
   localparam int LW  = (HW > LIMIT_W) ? HW : LIMIT_W;
   localparam int LKW = SW + 1;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type       state_ff, state_in;
   logic            op_ff, op_in;
   logic [XW-1:0]   idx_ff, idx_in;
   logic [SW-1:0]   head_ff, head_in;
   logic            head_valid_ff, head_valid_in;
   logic [HW-1:0]   hw_ff, hw_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            accept;
   logic            go;
   logic            full;
   logic            free_bad;
   logic [XW-1:0]   req_idx_x;

   logic            link_wr_en;
   logic [SW-1:0]   link_wr_addr;
   logic [LKW-1:0]  link_wr_data;
   logic [LKW-1:0]  link_rd_data;
   logic            use_wr_en;
   logic [SW-1:0]   use_wr_addr;
   logic            use_wr_data;
   logic            use_rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_idx_x = XW'(req_word.item_index);
   // result slot free or being drained this cycle
   assign go        = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign full     = (LW'(hw_ff) >= LW'(limit)) || (LW'(hw_ff) >= LW'(CAPACITY));
   assign free_bad = ((XW + 1)'(idx_ff) >= (XW + 1)'(hw_ff)) || !use_rd_data;

   // links: {valid of next, next slot}
   fli_ram #(.WIDTH(LKW), .DEPTH(CAPACITY), .AW(SW)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (link_rd_data)
   );

   // in-use bits; entries at or above the high-water mark are read but rejected by the range check
   fli_ram #(.WIDTH(1), .DEPTH(CAPACITY), .AW(SW)) u_use_ram (
      .clock   (clock),
      .wr_en   (use_wr_en),
      .wr_addr (use_wr_addr),
      .wr_data (use_wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx_x[SW-1:0]),
      .rd_data (use_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      hw_in         = hw_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      link_wr_en    = 1'b0;
      link_wr_addr  = idx_ff[SW-1:0];
      link_wr_data  = {head_valid_ff, head_ff};
      use_wr_en     = 1'b0;
      use_wr_addr   = idx_ff[SW-1:0];
      use_wr_data   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_word.op;
               idx_in   = req_idx_x;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.granted_index = '0;
               rsp_in.status        = STATUS_OK;
               if (op_ff == OP_ALLOC) begin
                  if (head_valid_ff) begin
                     // pop the free list
                     rsp_in.granted_index = IDX_W'(XW'(head_ff));
                     head_in       = link_rd_data[SW-1:0];
                     head_valid_in = link_rd_data[SW];
                     use_wr_en     = 1'b1;
                     use_wr_addr   = head_ff;
                     use_wr_data   = 1'b1;
                  end else if (full) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     rsp_in.granted_index = IDX_W'(XW'(hw_ff[SW-1:0]));
                     hw_in       = hw_ff + HW'(1);
                     use_wr_en   = 1'b1;
                     use_wr_addr = hw_ff[SW-1:0];
                     use_wr_data = 1'b1;
                  end
               end else begin
                  if (free_bad) begin
                     rsp_in.status = STATUS_IGNORED;
                  end else begin
                     link_wr_en    = 1'b1;
                     use_wr_en     = 1'b1;
                     head_in       = idx_ff[SW-1:0];
                     head_valid_in = 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         hw_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         hw_ff         <= hw_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff  <= op_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/free_list_index_allocator_top.sv =====
// Top level of the free-list slot allocator: limit register and engine.
// Each request word is handled as a memory read, then an update and write back; the update waits
// while a result is stalled in the output register, and no new request word is accepted until it is done.
// Requests are taken while an earlier result still waits in the output register.
// Reset empties the free list, clears the high-water mark and sets the limit to 1024.
// No clearing pass: the memories need none, so words are accepted right after reset.
`timescale 1ns / 1ps
`default_nettype none
module free_list_index_allocator_top #(
   parameter int CAPACITY = fli_pkg::CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [fli_pkg::LIMIT_W-1:0] csr_data,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire fli_pkg::req_type            req_word,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      fli_pkg::rsp_type            rsp_word
);
   import fli_pkg::*;

   logic [LIMIT_W-1:0] limit_ff, limit_in;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   fli_engine #(.CAPACITY(CAPACITY)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the free-list slot allocator top level.
`timescale 1ns / 1ps
module testbench;
   import fli_pkg::*;

   localparam int SLOTS       = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_word;

   free_list_index_allocator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   // allocator mirror, updated as words are accepted
   logic [IDX_W-1:0]   link_slot  [SLOTS];
   bit                 link_valid [SLOTS];
   bit                 slot_taken [SLOTS];
   logic [IDX_W-1:0]   top_slot   = '0;
   bit                 top_valid  = 1'b0;
   logic [LIMIT_W-1:0] hw_mark    = '0;
   logic [LIMIT_W-1:0] limit_reg  = LIMIT_RESET;

   req_type pending_q[$];
   rsp_type grant_q[$];

   int  sent_n      = 0;
   int  accepted_n  = 0;
   int  rsp_n       = 0;
   int  full_n      = 0;
   int  ignored_n   = 0;
   int  errors      = 0;
   int  cycle_n     = 0;
   bit  calm        = 1'b0;
   int  hold_asks   = 0;
   int  hold_served = 0;
   int  hold_left   = 0;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         link_slot[i]  = '0;
         link_valid[i] = 1'b0;
         slot_taken[i] = 1'b0;
      end
   end

   task automatic compute_grant(input req_type w, output rsp_type r);
      int eff_limit;
      int slot;
      r = '0;
      if (w.op == OP_ALLOC) begin
         if (top_valid) begin
            slot             = top_slot;
            top_valid        = link_valid[slot];
            top_slot         = link_slot[slot];
            slot_taken[slot] = 1'b1;
            r.granted_index  = slot[IDX_W-1:0];
            r.status         = STATUS_OK;
         end else begin
            eff_limit = (limit_reg > SLOTS) ? SLOTS : limit_reg;
            if (hw_mark >= eff_limit) begin
               r.status = STATUS_FULL;
            end else begin
               slot             = hw_mark;
               hw_mark          = hw_mark + 1'b1;
               slot_taken[slot] = 1'b1;
               r.granted_index  = slot[IDX_W-1:0];
               r.status         = STATUS_OK;
            end
         end
      end else if (w.item_index >= hw_mark || !slot_taken[w.item_index]) begin
         r.status = STATUS_IGNORED;
      end else begin
         link_slot[w.item_index]  = top_slot;
         link_valid[w.item_index] = top_valid;
         slot_taken[w.item_index] = 1'b0;
         top_slot                 = w.item_index;
         top_valid                = 1'b1;
         r.status                 = STATUS_OK;
      end
   endtask

   // monitor: csr writes, results, accepted requests
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      rsp_type grant;
      if (!reset) begin
         if (csr_valid && csr_ready)
            limit_reg = csr_data;
         if (rsp_valid && !rsp_stall) begin
            got = rsp_word;
            rsp_n++;
            if (grant_q.size() == 0) begin
               $error("result word with nothing expected: index %0d status %0d",
                      got.granted_index, got.status);
               errors++;
            end else begin
               want = grant_q.pop_front();
               if (got.granted_index !== want.granted_index) begin
                  $error("granted_index: expected %0d, actual %0d",
                         want.granted_index, got.granted_index);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            compute_grant(req_word, grant);
            if (grant.status == STATUS_FULL)
               full_n++;
            if (grant.status == STATUS_IGNORED)
               ignored_n++;
            grant_q.push_back(grant);
            accepted_n++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && accepted_n != sent_n) begin
         // word still offered, hold it
      end else if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
         req_word  <= pending_q.pop_front();
         req_valid <= 1'b1;
         sent_n++;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_served < hold_asks) begin
         hold_served++;
         hold_left = 299;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 17);
      end
   end

   always @(posedge clock) begin
      cycle_n++;
      if (cycle_n > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_n);
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_type mk_req(logic op, logic [IDX_W-1:0] idx);
      req_type w;
      w.op         = op;
      w.item_index = idx;
      return w;
   endfunction

   task automatic drain();
      while (pending_q.size() != 0 || accepted_n != sent_n || grant_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // some slot currently handed out, or a random index if there is none
   function automatic logic [IDX_W-1:0] pick_taken();
      int start;
      int s;
      if (hw_mark != 0) begin
         start = $urandom_range(int'(hw_mark) - 1);
         for (int k = 0; k < int'(hw_mark); k++) begin
            s = (start + k) % int'(hw_mark);
            if (slot_taken[s])
               return s[IDX_W-1:0];
         end
      end
      return IDX_W'($urandom_range(SLOTS - 1));
   endfunction

   task automatic push_random(input int alloc_pct, input int noise_pct);
      logic [IDX_W-1:0] idx;
      while (pending_q.size() >= 2)
         @(negedge clock);
      if ($urandom_range(99) < alloc_pct) begin
         pending_q.push_back(mk_req(OP_ALLOC, IDX_W'($urandom_range(SLOTS - 1))));
      end else begin
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
               0: idx = IDX_W'($urandom_range(SLOTS - 1));
               1: idx = top_valid ? top_slot : IDX_W'($urandom_range(SLOTS - 1));
               default: idx = hw_mark[IDX_W-1:0];
            endcase
         end else begin
            idx = pick_taken();
         end
         pending_q.push_back(mk_req(OP_FREE, idx));
      end
   endtask

   task automatic run_phase(input int n, input int alloc_pct, input int noise_pct);
      for (int i = 0; i < n; i++)
         push_random(alloc_pct, noise_pct);
   endtask

   initial begin
      int extra;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing handed out yet: every free is out of range
      pending_q.push_back(mk_req(OP_FREE, 10'd0));
      pending_q.push_back(mk_req(OP_FREE, 10'h3FF));

      // zero limit: no bump allocation
      write_limit(11'd0);
      pending_q.push_back(mk_req(OP_ALLOC, 10'h3FF));
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));

      // one slot: full, free, double free, reuse from the list
      write_limit(11'd1);
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));
      pending_q.push_back(mk_req(OP_ALLOC, 10'h155));
      pending_q.push_back(mk_req(OP_FREE, 10'd0));
      pending_q.push_back(mk_req(OP_FREE, 10'd0));
      pending_q.push_back(mk_req(OP_ALLOC, 10'h2AA));
      pending_q.push_back(mk_req(OP_FREE, 10'd5));
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));

      // limit above the table size is clamped; LIFO order of the list
      write_limit(11'd2047);
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));
      pending_q.push_back(mk_req(OP_FREE, 10'd1));
      pending_q.push_back(mk_req(OP_FREE, 10'd2));
      pending_q.push_back(mk_req(OP_FREE, 10'd0));
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));
      pending_q.push_back(mk_req(OP_ALLOC, 10'd0));
      pending_q.push_back(mk_req(OP_FREE, 10'd3));
      pending_q.push_back(mk_req(OP_FREE, 10'd4));
      pending_q.push_back(mk_req(OP_FREE, 10'h3FF));

      write_limit(11'd16);
      run_phase(30, 60, 20);

      write_limit(11'd64);
      calm = 1'b1;
      run_phase(30, 60, 15);
      drain();
      calm = 1'b0;

      // limit below the high-water mark: only list reuse succeeds
      write_limit(11'd8);
      run_phase(25, 50, 20);

      // receiver holds off while requests keep coming
      write_limit(11'd300);
      hold_asks = 1;
      run_phase(40, 65, 15);

      // fill the whole table past the clamped limit
      write_limit(11'd2047);
      extra = 0;
      while (extra < 20) begin
         push_random(100, 0);
         if (hw_mark >= SLOTS)
            extra++;
      end

      write_limit(LIMIT_RESET);
      run_phase(20, 40, 20);

      write_limit(11'd1);
      run_phase(15, 45, 25);

      write_limit(11'd0);
      run_phase(15, 45, 25);

      drain();
      repeat (8) @(posedge clock);
      if (grant_q.size() != 0) begin
         $error("%0d expected results never arrived", grant_q.size());
         errors++;
      end
      $display("covered %0d requests and %0d results: %0d full, %0d ignored",
               accepted_n, rsp_n, full_n, ignored_n);
      $display("limits 0, 1, 8 to 300, 1024 and 2047 used; high-water mark ended at %0d",
               hw_mark);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
